[sv/dqp_pkg.sv]
// Shared types and constants for the DNS question parser.
// No dependencies; used by every other file of the block.

package dqp_pkg;

   localparam int MAX_PACKET_DEFAULT = 1024;

   localparam int LEN_W = 11;
   localparam int POS_W = 11;

   // result kinds
   localparam logic [1:0] KIND_CHAR   = 2'd0;
   localparam logic [1:0] KIND_ACCEPT = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;

   // query type codes on accept
   localparam logic [1:0] QTYPE_A   = 2'd0;
   localparam logic [1:0] QTYPE_V6  = 2'd1;
   localparam logic [1:0] QTYPE_ALL = 2'd2;

   // header and label limits
   localparam logic [LEN_W-1:0] MIN_LENGTH   = 11'd12;
   localparam logic [LEN_W-1:0] TAIL_BYTES   = 11'd5;
   localparam logic [POS_W-1:0] COUNT_HI_POS = 11'd4;
   localparam logic [POS_W-1:0] COUNT_LO_POS = 11'd5;
   localparam logic [POS_W-1:0] LAST_HDR_POS = 11'd11;
   localparam logic [7:0]       LABEL_LIMIT  = 8'd64;
   localparam logic [7:0]       TYPE_CODE_A    = 8'h01;
   localparam logic [7:0]       TYPE_CODE_AAAA = 8'h1c;
   localparam logic [7:0]       TYPE_CODE_ANY  = 8'hff;
   localparam logic [7:0]       DOT_CHAR       = 8'h2e;

   typedef struct packed {
      logic             start_of_packet;
      logic [7:0]       byte_value;
      logic [LEN_W-1:0] packet_length;
   } req_type;

   typedef struct packed {
      logic [1:0] result_kind;
      logic [7:0] name_char;
      logic [1:0] query_type;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } step_result_type;

endpackage

[sv/dqp_parse_core.sv]
// Parse state and one-byte step of the DNS question parser.
// Depends on dqp_pkg.

module dqp_parse_core #(
   parameter int MaxPacket = dqp_pkg::MAX_PACKET_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  dqp_pkg::req_type         item,
   output dqp_pkg::step_result_type result
);

   typedef enum logic [2:0] {
      PH_IDLE, PH_HEADER, PH_LEN_FIRST, PH_LEN_NEXT,
      PH_LABEL, PH_TYPE_HI, PH_TYPE_LO, PH_DONE
   } phase_type;

   localparam int LW = dqp_pkg::LEN_W;

   phase_type      phase_ff, phase_in;
   logic [LW-1:0]  pos_ff, pos_in;
   logic [LW-1:0]  len_ff, len_in;
   logic [5:0]     lrem_ff, lrem_in;
   logic [7:0]     type_hi_ff, type_hi_in;
   logic [7:0]     count_hi_ff, count_hi_in;

   phase_type      ph;
   logic [LW-1:0]  len, lim;
   logic [LW:0]    label_end, pos_next;
   logic [5:0]     lrem_dec;
   logic           bad_length, found, emit;
   logic [1:0]     kind, qtype;
   logic [7:0]     ch, b;

   always_comb begin
      b = item.byte_value;
      // a start byte reloads the packet context before anything else
      if (item.start_of_packet) begin
         ph = PH_HEADER;
         len = item.packet_length;
         pos_in = '0;
         lrem_in = '0;
         type_hi_in = '0;
         count_hi_in = '0;
      end else begin
         ph = phase_ff;
         len = len_ff;
         pos_in = pos_ff;
         lrem_in = lrem_ff;
         type_hi_in = type_hi_ff;
         count_hi_in = count_hi_ff;
      end
      len_in = len;
      phase_in = ph;
      bad_length = item.start_of_packet &&
         (len < dqp_pkg::MIN_LENGTH || 32'(len) > 32'(MaxPacket));
      lim = len - dqp_pkg::TAIL_BYTES;
      label_end = {1'b0, pos_in} + 12'd1 + 12'(b);
      pos_next = {1'b0, pos_in} + 12'd1;
      lrem_dec = lrem_in - 6'd1;
      emit = 1'b0;
      found = 1'b0;
      kind = dqp_pkg::KIND_CHAR;
      ch = '0;
      qtype = dqp_pkg::QTYPE_A;

      if (bad_length) begin
         emit = 1'b1;
         kind = dqp_pkg::KIND_REJECT;
         phase_in = PH_DONE;
      end else if (ph != PH_IDLE && ph != PH_DONE) begin
         unique case (ph)
            PH_HEADER: begin
               if (pos_in == dqp_pkg::COUNT_HI_POS) begin
                  count_hi_in = b;
               end else if (pos_in == dqp_pkg::COUNT_LO_POS) begin
                  if ({count_hi_in, b} != 16'd1) begin
                     emit = 1'b1;
                     kind = dqp_pkg::KIND_REJECT;
                  end
               end
               if (pos_in >= dqp_pkg::LAST_HDR_POS) phase_in = PH_LEN_FIRST;
            end
            PH_LEN_FIRST, PH_LEN_NEXT: begin
               // after a label a zero byte terminates even at the limit
               if (ph == PH_LEN_NEXT && b == 8'd0) begin
                  phase_in = PH_TYPE_HI;
               end else if (pos_in >= lim || b >= dqp_pkg::LABEL_LIMIT ||
                            label_end > {1'b0, lim}) begin
                  emit = 1'b1;
                  kind = dqp_pkg::KIND_REJECT;
               end else if (b == 8'd0) begin
                  phase_in = PH_TYPE_HI;
               end else begin
                  if (ph == PH_LEN_NEXT) begin
                     emit = 1'b1;
                     ch = dqp_pkg::DOT_CHAR;
                  end
                  lrem_in = b[5:0];
                  phase_in = PH_LABEL;
               end
            end
            PH_LABEL: begin
               emit = 1'b1;
               ch = b;
               lrem_in = lrem_dec;
               if (lrem_dec == 6'd0) phase_in = PH_LEN_NEXT;
            end
            PH_TYPE_HI: begin
               type_hi_in = b;
               phase_in = PH_TYPE_LO;
            end
            default: begin
               emit = 1'b1;
               found = type_hi_in == 8'd0;
               priority if (found && b == dqp_pkg::TYPE_CODE_A) begin
                  kind = dqp_pkg::KIND_ACCEPT;
                  qtype = dqp_pkg::QTYPE_A;
               end else if (found && b == dqp_pkg::TYPE_CODE_AAAA) begin
                  kind = dqp_pkg::KIND_ACCEPT;
                  qtype = dqp_pkg::QTYPE_V6;
               end else if (found && b == dqp_pkg::TYPE_CODE_ANY) begin
                  kind = dqp_pkg::KIND_ACCEPT;
                  qtype = dqp_pkg::QTYPE_ALL;
               end else begin
                  kind = dqp_pkg::KIND_REJECT;
               end
            end
         endcase
         // last byte with no verdict yet turns into a reject
         if (!(emit && kind != dqp_pkg::KIND_CHAR) && pos_next >= {1'b0, len}) begin
            emit = 1'b1;
            kind = dqp_pkg::KIND_REJECT;
            ch = '0;
         end
         if (emit && kind != dqp_pkg::KIND_CHAR) phase_in = PH_DONE;
         if (pos_in != {LW{1'b1}}) pos_in = pos_next[LW-1:0];
      end

      result.valid = emit;
      result.data.result_kind = kind;
      result.data.name_char = (kind == dqp_pkg::KIND_CHAR) ? ch : 8'd0;
      result.data.query_type = (kind == dqp_pkg::KIND_ACCEPT) ? qtype : dqp_pkg::QTYPE_A;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pos_ff <= '0;
         len_ff <= '0;
         lrem_ff <= '0;
         type_hi_ff <= '0;
         count_hi_ff <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         pos_ff <= pos_in;
         len_ff <= len_in;
         lrem_ff <= lrem_in;
         type_hi_ff <= type_hi_in;
         count_hi_ff <= count_hi_in;
      end
   end

endmodule

[sv/dns_question_parser.sv]
// A request taken into the input register is stepped by the parse core, and its
// result is registered. Throughput: one request per cycle while rsp is not stalled;
// parse step between input and result registers; state updates once per byte.
// Bytes that produce no result leave nothing on the response channel.
// Reset (synchronous, active high) empties both registers and sets the parser idle.
// Top level of the DNS question parser; depends on dqp_pkg and dqp_parse_core.

module dns_question_parser #(
   parameter int MaxPacket = dqp_pkg::MAX_PACKET_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dqp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dqp_pkg::rsp_type rsp_data
);

   logic                     in_valid_ff, in_valid_in;
   dqp_pkg::req_type         in_data_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   dqp_pkg::rsp_type         rsp_data_ff;
   logic                     advance, step_en, req_take;
   dqp_pkg::step_result_type step_res;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign step_en = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_take = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance ? (step_en && step_res.valid) : rsp_valid_ff;

   dqp_parse_core #(.MaxPacket(MaxPacket)) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (in_data_ff),
      .result  (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_take) in_data_ff <= req_data;
      if (step_en && step_res.valid) rsp_data_ff <= step_res.data;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

[sv/dqp_checker.sv]
// Port-level checks for the DNS question parser, bound to its top level.
// Depends on dqp_pkg.

module dqp_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input dqp_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.result_kind == dqp_pkg::KIND_CHAR ||
                     rsp_data.result_kind == dqp_pkg::KIND_ACCEPT ||
                     rsp_data.result_kind == dqp_pkg::KIND_REJECT))
      else $error("illegal result kind");

   a_char_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind != dqp_pkg::KIND_CHAR |->
         rsp_data.name_char == 8'd0)
      else $error("name character set on a verdict");

   a_qtype_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind != dqp_pkg::KIND_ACCEPT |->
         rsp_data.query_type == dqp_pkg::QTYPE_A)
      else $error("query type set without accept");

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind dns_question_parser dqp_checker u_dqp_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[sim/tb_dns_question_parser.sv]
// Self-checking testbench for dns_question_parser: directed packets for each parse rule,
// then random well-formed and broken packets under several idle and stall mixes.
// Depends on dqp_pkg and the dns_question_parser RTL.

module tb_dns_question_parser;

   localparam int MAX_PACKET     = dqp_pkg::MAX_PACKET_DEFAULT;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_LIMIT    = 1000;
   localparam int HOLD_CYCLES    = 300;

   typedef logic [7:0] octet_queue_type[$];

   typedef enum logic [2:0] {
      ST_IDLE, ST_HEADER, ST_LEN_FIRST, ST_LEN_NEXT,
      ST_LABEL, ST_TYPE_HI, ST_TYPE_LO, ST_DONE
   } parse_state_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   dqp_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   dqp_pkg::rsp_type rsp_data;

   dns_question_parser u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   // predictor state
   logic [dqp_pkg::POS_W-1:0] pos = '0;
   logic [dqp_pkg::LEN_W-1:0] held_len = '0;
   parse_state_type           phase = ST_IDLE;
   logic [5:0]                label_left = '0;
   logic [7:0]                type_hi = '0;
   logic [7:0]                count_hi = '0;

   dqp_pkg::rsp_type pending_results[$];
   dqp_pkg::rsp_type predicted, wanted;

   logic [7:0] good_types[3] = '{dqp_pkg::TYPE_CODE_A, dqp_pkg::TYPE_CODE_AAAA,
                                 dqp_pkg::TYPE_CODE_ANY};

   int errors = 0;
   int n_chars = 0;
   int n_accepts = 0;
   int n_rejects = 0;
   int n_packets = 0;
   int bytes_sent = 0;
   int quiet_cycles = 0;
   int hold_left = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   function automatic bit parse_byte(input dqp_pkg::req_type r, output dqp_pkg::rsp_type res);
      bit         emit;
      logic [1:0] kind;
      logic [7:0] chr;
      logic [1:0] qt;
      int         p, lim, b;
      emit = 1'b0;
      kind = dqp_pkg::KIND_CHAR;
      chr  = '0;
      qt   = dqp_pkg::QTYPE_A;
      res  = '0;
      b    = r.byte_value;
      if (r.start_of_packet) begin
         held_len   = r.packet_length;
         pos        = '0;
         label_left = '0;
         type_hi    = '0;
         count_hi   = '0;
         phase      = ST_HEADER;
         if (held_len < dqp_pkg::MIN_LENGTH || held_len > MAX_PACKET) begin
            phase = ST_DONE;
            res.result_kind = dqp_pkg::KIND_REJECT;
            return 1'b1;
         end
      end
      if (phase == ST_IDLE || phase == ST_DONE) return 1'b0;
      p   = pos;
      lim = held_len - dqp_pkg::TAIL_BYTES;
      unique case (phase)
         ST_HEADER: begin
            if (p == dqp_pkg::COUNT_HI_POS) begin
               count_hi = r.byte_value;
            end else if (p == dqp_pkg::COUNT_LO_POS &&
                         {count_hi, r.byte_value} != 16'd1) begin
               emit = 1'b1;
               kind = dqp_pkg::KIND_REJECT;
            end
            if (p >= dqp_pkg::LAST_HDR_POS) phase = ST_LEN_FIRST;
         end
         ST_LEN_FIRST, ST_LEN_NEXT: begin
            if (phase == ST_LEN_NEXT && b == 0) begin
               phase = ST_TYPE_HI;
            end else if (p >= lim || b >= dqp_pkg::LABEL_LIMIT || p + 1 + b > lim) begin
               emit = 1'b1;
               kind = dqp_pkg::KIND_REJECT;
            end else if (b == 0) begin
               phase = ST_TYPE_HI;   // empty name
            end else begin
               if (phase == ST_LEN_NEXT) begin
                  emit = 1'b1;
                  chr  = dqp_pkg::DOT_CHAR;
               end
               label_left = 6'(b);
               phase = ST_LABEL;
            end
         end
         ST_LABEL: begin
            emit = 1'b1;
            chr  = r.byte_value;
            label_left = label_left - 6'd1;
            if (label_left == 6'd0) phase = ST_LEN_NEXT;
         end
         ST_TYPE_HI: begin
            type_hi = r.byte_value;
            phase = ST_TYPE_LO;
         end
         default: begin
            emit = 1'b1;
            kind = dqp_pkg::KIND_ACCEPT;
            if (type_hi == 8'h00 && r.byte_value == dqp_pkg::TYPE_CODE_A)
               qt = dqp_pkg::QTYPE_A;
            else if (type_hi == 8'h00 && r.byte_value == dqp_pkg::TYPE_CODE_AAAA)
               qt = dqp_pkg::QTYPE_V6;
            else if (type_hi == 8'h00 && r.byte_value == dqp_pkg::TYPE_CODE_ANY)
               qt = dqp_pkg::QTYPE_ALL;
            else
               kind = dqp_pkg::KIND_REJECT;
         end
      endcase
      // last byte without a verdict turns into a reject
      if ((!emit || kind == dqp_pkg::KIND_CHAR) && p + 1 >= held_len) begin
         emit = 1'b1;
         kind = dqp_pkg::KIND_REJECT;
      end
      if (emit && kind != dqp_pkg::KIND_CHAR) phase = ST_DONE;
      if (pos != '1) pos = pos + 1'b1;
      res.result_kind = kind;
      res.name_char   = (kind == dqp_pkg::KIND_CHAR) ? chr : 8'h00;
      res.query_type  = (kind == dqp_pkg::KIND_ACCEPT) ? qt : dqp_pkg::QTYPE_A;
      return emit;
   endfunction

   task automatic note_error(input string what);
      errors++;
      if (errors <= 10) $display("ERROR at %0t: %s", $time, what);
   endtask

   // result checker and request monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               note_error($sformatf("unexpected result kind=%0d char=%02h qtype=%0d",
                  rsp_data.result_kind, rsp_data.name_char, rsp_data.query_type));
            end else begin
               wanted = pending_results.pop_front();
               if (rsp_data.result_kind !== wanted.result_kind ||
                   rsp_data.name_char !== wanted.name_char ||
                   rsp_data.query_type !== wanted.query_type)
                  note_error($sformatf(
                     "expected kind=%0d char=%02h qtype=%0d, got kind=%0d char=%02h qtype=%0d",
                     wanted.result_kind, wanted.name_char, wanted.query_type,
                     rsp_data.result_kind, rsp_data.name_char, rsp_data.query_type));
               unique case (wanted.result_kind)
                  dqp_pkg::KIND_CHAR:   n_chars++;
                  dqp_pkg::KIND_ACCEPT: n_accepts++;
                  default:              n_rejects++;
               endcase
            end
         end
         if (req_valid && !req_stall && parse_byte(req_data, predicted))
            pending_results.push_back(predicted);
      end
   end

   // receiver: random stall, or a counted hold-off
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
         $display("Some tests failed");
         $finish;
      end
   end

   // called and returns at a falling edge; valid stays high for back-to-back requests
   task automatic send_request(input dqp_pkg::req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_packet(input octet_queue_type pkt, input int len);
      dqp_pkg::req_type r;
      n_packets++;
      foreach (pkt[i]) begin
         r.start_of_packet = (i == 0);
         r.byte_value      = pkt[i];
         r.packet_length   = dqp_pkg::LEN_W'(len);
         send_request(r);
      end
   endtask

   task automatic send_stray(input int n);
      dqp_pkg::req_type r;
      repeat (n) begin
         r.start_of_packet = 1'b0;
         r.byte_value      = 8'($urandom);
         r.packet_length   = dqp_pkg::LEN_W'($urandom);
         send_request(r);
      end
   endtask

   function automatic octet_queue_type build_query(input int n_labels, input int min_label,
         input int max_label, input logic [15:0] qdcount, input logic [15:0] qtype,
         input int pad);
      octet_queue_type pkt;
      int              n;
      for (int i = 0; i < 12; i++) pkt.push_back(8'($urandom));
      pkt[4] = qdcount[15:8];
      pkt[5] = qdcount[7:0];
      for (int l = 0; l < n_labels; l++) begin
         n = $urandom_range(max_label, min_label);
         pkt.push_back(8'(n));
         repeat (n) pkt.push_back(8'($urandom));
      end
      pkt.push_back(8'h00);
      pkt.push_back(qtype[15:8]);
      pkt.push_back(qtype[7:0]);
      pkt.push_back(8'h00);   // class IN
      pkt.push_back(8'h01);
      repeat (pad) pkt.push_back(8'($urandom));
      return pkt;
   endfunction

   task automatic wait_results_drained();
      int spent;
      spent = 0;
      while (pending_results.size() > 0 && spent < DRAIN_LIMIT) begin
         @(negedge clock);
         spent++;
      end
   endtask

   task automatic test_stray_bytes();
      // nothing has started yet: all ignored
      send_stray(4);
   endtask

   task automatic test_query_types();
      octet_queue_type pkt;
      pkt = build_query(2, 1, 6, 16'd1, {8'h00, dqp_pkg::TYPE_CODE_A}, 0);
      send_packet(pkt, pkt.size());
      pkt = build_query(3, 1, 6, 16'd1, {8'h00, dqp_pkg::TYPE_CODE_AAAA}, 0);
      send_packet(pkt, pkt.size());
      pkt = build_query(1, 1, 6, 16'd1, {8'h00, dqp_pkg::TYPE_CODE_ANY}, 2);
      send_packet(pkt, pkt.size());
      pkt = build_query(1, 1, 6, 16'd1, 16'h0002, 0);
      send_packet(pkt, pkt.size());
      pkt = build_query(1, 1, 6, 16'd1, {8'h01, dqp_pkg::TYPE_CODE_A}, 0);
      send_packet(pkt, pkt.size());
   endtask

   task automatic test_question_count();
      octet_queue_type pkt;
      logic [15:0]     counts[5] = '{16'h0000, 16'h0002, 16'h0100, 16'h0101, 16'hffff};
      foreach (counts[i]) begin
         pkt = build_query(1, 1, 4, counts[i], {8'h00, dqp_pkg::TYPE_CODE_A}, 0);
         send_packet(pkt, pkt.size());
      end
   endtask

   task automatic test_length_bounds();
      octet_queue_type pkt;
      int              bad_lengths[4] = '{0, 11, MAX_PACKET + 1, 2047};
      foreach (bad_lengths[i]) begin
         pkt = build_query(1, 1, 3, 16'd1, {8'h00, dqp_pkg::TYPE_CODE_A}, 0);
         send_packet(pkt, bad_lengths[i]);
      end
      // header only: no verdict before the last byte
      pkt = build_query(0, 1, 1, 16'd1, {8'h00, dqp_pkg::TYPE_CODE_A}, 0);
      while (pkt.size() > 12) void'(pkt.pop_back());
      send_packet(pkt, 12);
      // largest legal length is taken; the question still ends in an accept
      pkt = build_query(1, 10, 10, 16'd1, {8'h00, dqp_pkg::TYPE_CODE_ANY}, 0);
      send_packet(pkt, MAX_PACKET);
   endtask

   task automatic test_label_limits();
      octet_queue_type pkt;
      pkt = build_query(1, 63, 63, 16'd1, {8'h00, dqp_pkg::TYPE_CODE_A}, 0);
      send_packet(pkt, pkt.size());
      pkt = build_query(1, 64, 64, 16'd1, {8'h00, dqp_pkg::TYPE_CODE_A}, 0);
      send_packet(pkt, pkt.size());
      // compression pointer in place of a length
      pkt = build_query(2, 2, 5, 16'd1, {8'h00, dqp_pkg::TYPE_CODE_A}, 0);
      pkt[12] = 8'hc0;
      send_packet(pkt, pkt.size());
      // label runs past length-5
      pkt = build_query(1, 10, 10, 16'd1, {8'h00, dqp_pkg::TYPE_CODE_A}, 0);
      send_packet(pkt, pkt.size() - 2);
      // empty name right at length-5 is rejected, one byte earlier it is fine
      pkt = build_query(0, 1, 1, 16'd1, {8'h00, dqp_pkg::TYPE_CODE_A}, 0);
      send_packet(pkt, pkt.size());
      pkt = build_query(0, 1, 1, 16'd1, {8'h00, dqp_pkg::TYPE_CODE_AAAA}, 1);
      send_packet(pkt, pkt.size());
   endtask

   task automatic test_early_end();
      octet_queue_type pkt;
      // length cuts the packet inside a label
      pkt = build_query(2, 8, 8, 16'd1, {8'h00, dqp_pkg::TYPE_CODE_A}, 0);
      send_packet(pkt, 20);
      send_stray(3);
      // new start in mid-packet abandons the old one
      pkt = build_query(2, 6, 6, 16'd1, {8'h00, dqp_pkg::TYPE_CODE_A}, 0);
      while (pkt.size() > 18) void'(pkt.pop_back());
      send_packet(pkt, 40);
      pkt = build_query(2, 1, 6, 16'd1, {8'h00, dqp_pkg::TYPE_CODE_ANY}, 0);
      send_packet(pkt, pkt.size());
      send_stray(3);
   endtask

   task automatic test_backpressure();
      octet_queue_type pkt;
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_left     = HOLD_CYCLES;
      repeat (2) begin
         pkt = build_query(3, 4, 12, 16'd1, {8'h00, good_types[$urandom_range(2)]}, 0);
         send_packet(pkt, pkt.size());
      end
      wait_results_drained();
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_p, input int n_bytes);
      octet_queue_type pkt;
      logic [15:0]     qtype, qdcount;
      int              pick, len, stop_at;
      send_idle_pct = idle_pct;
      stall_pct     = stall_p;
      stop_at = bytes_sent + n_bytes;
      while (bytes_sent < stop_at) begin
         pick = $urandom_range(99);
         qtype[15:8] = ($urandom_range(4) != 0) ? 8'h00 : 8'($urandom);
         qtype[7:0]  = ($urandom_range(4) != 0) ? good_types[$urandom_range(2)] : 8'($urandom);
         qdcount = ($urandom_range(14) != 0) ? 16'd1 :
                   ($urandom_range(1) ? 16'($urandom_range(3)) : 16'($urandom));
         pkt = build_query($urandom_range(4), 1, ($urandom_range(9) == 0) ? 63 : 10,
                           qdcount, qtype, $urandom_range(2));
         len = pkt.size();
         if (pick < 70) begin
            send_packet(pkt, len);
         end else if (pick < 80) begin
            send_packet(pkt, len + $urandom_range(8) - 4);
         end else if (pick < 88) begin
            while (pkt.size() > 1 && $urandom_range(3) != 0) void'(pkt.pop_back());
            send_packet(pkt, len);
         end else if (pick < 95) begin
            pkt[$urandom_range(len - 1, 12)] = 8'($urandom);
            send_packet(pkt, len);
         end else begin
            pkt.delete();
            repeat ($urandom_range(20, 1)) pkt.push_back(8'($urandom));
            if ($urandom_range(1)) send_packet(pkt, $urandom_range(2047));
            else send_stray(pkt.size());
         end
      end
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      test_stray_bytes();
      test_query_types();
      test_question_count();
      test_length_bounds();
      test_label_limits();
      test_early_end();
      test_backpressure();
      test_random_traffic(0, 0, 80);
      test_random_traffic(88, 0, 80);
      test_random_traffic(0, 88, 80);
      test_random_traffic(20, 20, 80);
      req_valid <= 1'b0;
      wait_results_drained();
      repeat (8) @(negedge clock);
      if (pending_results.size() > 0)
         note_error($sformatf("%0d expected results never arrived", pending_results.size()));
      $display("Covered %0d packets in %0d request bytes under four idle/stall mixes",
               n_packets, bytes_sent);
      $display("Checked %0d name characters, %0d accepts, %0d rejects; %0d errors",
               n_chars, n_accepts, n_rejects, errors);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
